// ----- design/stereo_comb_allpass_reverb_unit_macros.svh -----
// Assertion macros for the reverb unit.
`ifndef STEREO_COMB_ALLPASS_REVERB_UNIT_MACROS_SVH
`define STEREO_COMB_ALLPASS_REVERB_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SCAR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("reverb unit assertion failed");
// next-cycle implication
`define SCAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("reverb unit assertion failed");
`else
`define SCAR_ASSERT_IMPL(label, ante, cons)
`define SCAR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/scar_pkg.sv -----
package scar_pkg;

    // default sizes
    localparam int COMB_COUNT_DEF    = 8;
    localparam int ALLPASS_COUNT_DEF = 4;
    localparam int COMB_DEPTH_DEF    = 2048;
    localparam int ALLPASS_DEPTH_DEF = 1024;
    localparam int SAMPLE_WIDTH_DEF  = 24;

    // delay tunings at 44.1 kHz; all below the default depths
    localparam int COMB_TUNE [8] = '{1557, 1617, 1491, 1422, 1277, 1356, 1188, 1116};
    localparam int AP_TUNE [4]   = '{556, 441, 341, 225};

    // Q1.15 gain constants
    localparam int GAIN_W    = 16;
    localparam int Q15_ONE   = 32768;
    localparam int Q15_HALF  = 16384;
    localparam int Q15_SHIFT = 15;

    // feedback = round(size * 9 / 10) + 0.1; divide by 10 via reciprocal
    localparam int FB_X_W     = 19;
    localparam int FB_P_W     = 38;
    localparam int FB_RECIP   = 419431;
    localparam int FB_SHIFT   = 22;
    localparam int FB_OFFSET  = 3277;

    // register defaults
    localparam logic [GAIN_W-1:0] RST_ROOM_SIZE = 16'd14564;
    localparam logic [GAIN_W-1:0] RST_WET_GAIN  = 16'd10923;
    localparam logic [GAIN_W-1:0] RST_DRY_GAIN  = 16'd32768;

    // register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROOM_SIZE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WET_GAIN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DRY_GAIN  = 2'd2;

endpackage

// ----- design/scar_delay_ram.sv -----
module scar_delay_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/stereo_comb_allpass_reverb_unit.sv -----
// Frames are processed one at a time: a new request is taken only after the previous result
// is loaded into the output registers, which waits on out_ready. Each frame's processing is serial,
// paced by one comb memory access per line, the serial all-pass chain and the shared multiplier.
// Reset: registers to defaults, delay positions and fill count to zero; entries not yet
// written read as zero through the fill count, so no memory clearing pass is needed.
`include "stereo_comb_allpass_reverb_unit_macros.svh"
module stereo_comb_allpass_reverb_unit #(
    parameter int COMB_COUNT    = scar_pkg::COMB_COUNT_DEF,
    parameter int ALLPASS_COUNT = scar_pkg::ALLPASS_COUNT_DEF,
    parameter int COMB_DEPTH    = scar_pkg::COMB_DEPTH_DEF,
    parameter int ALLPASS_DEPTH = scar_pkg::ALLPASS_DEPTH_DEF,
    parameter int SAMPLE_WIDTH  = scar_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [scar_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [scar_pkg::GAIN_W-1:0]            cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         left_in,
    input  logic signed [SAMPLE_WIDTH-1:0]         right_in,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         left_out,
    output logic signed [SAMPLE_WIDTH-1:0]         right_out
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int GW   = scar_pkg::GAIN_W;
    localparam int PW   = SW + GW + 1;
    localparam int RW   = SW + 2;
    localparam int XW   = SW + 3;
    localparam int ACW  = SW + $clog2(COMB_COUNT);
    localparam int CPW  = $clog2(COMB_DEPTH);
    localparam int APW  = $clog2(ALLPASS_DEPTH);
    localparam int CMD  = COMB_COUNT * COMB_DEPTH;
    localparam int CMW  = $clog2(CMD);
    localparam int APL  = 2 * ALLPASS_COUNT;
    localparam int AMD  = APL * ALLPASS_DEPTH;
    localparam int AMW  = $clog2(AMD);
    localparam int FW   = $clog2(COMB_DEPTH + 1);
    localparam int IW   = $clog2(COMB_COUNT);
    localparam int LW   = $clog2(APL);
    localparam int SIW  = (ALLPASS_COUNT > 1) ? $clog2(ALLPASS_COUNT) : 1;
    localparam int N    = COMB_COUNT;
    localparam int A    = ALLPASS_COUNT;
    localparam int ST_DRY_L = N + 1;
    localparam int ST_DRY_R = N + 2;
    localparam int ST_WET_L = N + 2 * A + 1;
    localparam int ST_WET_R = N + 2 * A + 2;
    localparam int ST_SUM_L = N + 2 * A + 2;
    localparam int ST_SUM_R = N + 2 * A + 3;
    localparam int STW  = $clog2(ST_SUM_R + 1);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_t;

    // saturate to the sample range
    function automatic logic signed [SW-1:0] sat(input logic signed [XW-1:0] v);
        logic signed [SW-1:0] r;
        if ((&v[XW-1:SW-1]) || !(|v[XW-1:SW-1]))
        begin
            r = v[SW-1:0];
        end
        else if (v[XW-1])
        begin
            r = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(SW-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic logic [GW-1:0] clamp_gain(input logic [GW-1:0] g);
        logic [GW-1:0] r;
        r = (g > GW'(scar_pkg::Q15_ONE)) ? GW'(scar_pkg::Q15_ONE) : g;
        return r;
    endfunction

    // control registers
    state_t               state_reg;
    logic [STW-1:0]       st_reg;
    logic                 out_valid_reg;
    logic [CPW-1:0]       comb_pos_reg;
    logic [APW-1:0]       ap_pos_reg;
    logic [FW-1:0]        frames_reg;
    logic [GW-1:0]        room_reg;
    logic [GW-1:0]        wet_reg;
    logic [GW-1:0]        dry_reg;

    // datapath registers
    logic signed [SW-1:0]  left_reg;
    logic signed [SW-1:0]  right_reg;
    logic signed [SW-1:0]  mono_reg;
    logic [scar_pkg::FB_P_W-1:0] fb_prod_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [ACW-1:0] acc_l_reg;
    logic signed [ACW-1:0] acc_r_reg;
    logic                  comb_ok_reg;
    logic                  ap_ok_reg;
    logic signed [SW-1:0]  x_reg;
    logic signed [SW-1:0]  rev_l_reg;
    logic signed [SW-1:0]  rev_r_reg;
    logic signed [RW-1:0]  dry_l_reg;
    logic signed [RW-1:0]  dry_r_reg;
    logic signed [SW-1:0]  sum_l_reg;
    logic signed [SW-1:0]  sum_r_reg;
    logic signed [SW-1:0]  out_left_reg;
    logic signed [SW-1:0]  out_right_reg;

    logic                  accept;
    logic                  run;
    logic                  out_load;

    assign accept   = in_valid && in_ready;
    assign run      = (state_reg == S_RUN);
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = out_left_reg;
    assign right_out = out_right_reg;

    // feedback gain from room size
    logic [GW-1:0]               room_c;
    logic [scar_pkg::FB_X_W-1:0] fb_x;
    logic [GW-1:0]               fb;
    logic [GW-1:0]               wet_c;
    logic [GW-1:0]               dry_c;

    assign room_c = clamp_gain(room_reg);
    assign wet_c  = clamp_gain(wet_reg);
    assign dry_c  = clamp_gain(dry_reg);
    assign fb_x   = scar_pkg::FB_X_W'(room_c) * scar_pkg::FB_X_W'(9)
                    + scar_pkg::FB_X_W'(5);
    assign fb     = GW'(fb_prod_reg[scar_pkg::FB_P_W-1:scar_pkg::FB_SHIFT])
                    + GW'(scar_pkg::FB_OFFSET);

    // step decode
    logic           comb_rd_en;
    logic           comb_dat_en;
    logic           comb_wr_en;
    logic [IW-1:0]  comb_rd_idx;
    logic [IW-1:0]  comb_dat_idx;
    logic [IW-1:0]  comb_wr_idx;
    logic           ap_rd_en;
    logic           ap_cmp_en;
    logic [LW-1:0]  ap_rd_k;
    logic [LW-1:0]  ap_cmp_k;
    logic           ap_rd_ch;
    logic           ap_cmp_ch;
    logic [SIW-1:0] ap_rd_s;
    logic [SIW-1:0] ap_cmp_s;

    assign comb_rd_en  = run && (st_reg < STW'(N));
    assign comb_dat_en = run && (st_reg >= STW'(1)) && (st_reg <= STW'(N));
    assign comb_wr_en  = run && (st_reg >= STW'(2)) && (st_reg <= STW'(N + 1));
    assign comb_rd_idx  = IW'(st_reg);
    assign comb_dat_idx = IW'(st_reg - STW'(1));
    assign comb_wr_idx  = IW'(st_reg - STW'(2));

    assign ap_rd_en  = run && (st_reg >= STW'(N)) && (st_reg < STW'(N + 2 * A));
    assign ap_cmp_en = run && (st_reg >= STW'(N + 1)) && (st_reg <= STW'(N + 2 * A));
    assign ap_rd_k   = LW'(st_reg - STW'(N));
    assign ap_cmp_k  = LW'(st_reg - STW'(N + 1));
    assign ap_rd_ch  = (ap_rd_k >= LW'(A));
    assign ap_cmp_ch = (ap_cmp_k >= LW'(A));
    assign ap_rd_s   = SIW'(ap_rd_ch ? (ap_rd_k - LW'(A)) : ap_rd_k);
    assign ap_cmp_s  = SIW'(ap_cmp_ch ? (ap_cmp_k - LW'(A)) : ap_cmp_k);

    // comb memory addressing
    logic [CPW-1:0] comb_d;
    logic [CPW-1:0] comb_r;
    logic [CMW-1:0] comb_raddr;
    logic [CMW-1:0] comb_waddr;
    logic [SW-1:0]  comb_rdata;
    logic signed [SW-1:0] comb_y;
    logic signed [RW-1:0] rnd;
    logic signed [PW-1:0] rnd_full;
    logic signed [SW-1:0] comb_wdata;

    assign comb_d = CPW'(scar_pkg::COMB_TUNE[3'(comb_rd_idx)]);
    assign comb_r = (comb_pos_reg >= comb_d) ? (comb_pos_reg - comb_d)
                    : CPW'(comb_pos_reg + CPW'(COMB_DEPTH) - comb_d);
    assign comb_raddr = CMW'(comb_rd_idx) * CMW'(COMB_DEPTH) + CMW'(comb_r);
    assign comb_waddr = CMW'(comb_wr_idx) * CMW'(COMB_DEPTH) + CMW'(comb_pos_reg);
    assign comb_y     = comb_ok_reg ? $signed(comb_rdata) : '0;

    // Q1.15 rounding, half up
    assign rnd_full   = (prod_reg + PW'(scar_pkg::Q15_HALF)) >>> scar_pkg::Q15_SHIFT;
    assign rnd        = rnd_full[RW-1:0];
    assign comb_wdata = sat(XW'(mono_reg) + XW'(rnd));

    scar_delay_ram #(
        .DEPTH (CMD),
        .WIDTH (SW)
    ) u_comb_ram (
        .clk   (clk),
        .we    (comb_wr_en),
        .waddr (comb_waddr),
        .wdata (comb_wdata),
        .raddr (comb_raddr),
        .rdata (comb_rdata)
    );

    // all-pass memory addressing and stage arithmetic
    logic [APW-1:0] ap_d;
    logic [APW-1:0] ap_r;
    logic [AMW-1:0] ap_raddr;
    logic [AMW-1:0] ap_waddr;
    logic [SW-1:0]  ap_rdata;
    logic signed [SW-1:0] ap_b;
    logic signed [SW-1:0] ap_x;
    logic signed [SW-1:0] ap_y;
    logic signed [XW-1:0] ap_half;
    logic signed [SW-1:0] ap_wdata;

    assign ap_d = APW'(scar_pkg::AP_TUNE[2'(ap_rd_s)]);
    assign ap_r = (ap_pos_reg >= ap_d) ? (ap_pos_reg - ap_d)
                  : APW'(ap_pos_reg + APW'(ALLPASS_DEPTH) - ap_d);
    assign ap_raddr = AMW'(ap_rd_k) * AMW'(ALLPASS_DEPTH) + AMW'(ap_r);
    assign ap_waddr = AMW'(ap_cmp_k) * AMW'(ALLPASS_DEPTH) + AMW'(ap_pos_reg);
    assign ap_b     = ap_ok_reg ? $signed(ap_rdata) : '0;
    assign ap_x     = (ap_cmp_s == '0) ? (ap_cmp_ch ? sat(XW'(acc_r_reg)) : sat(XW'(acc_l_reg)))
                      : x_reg;
    assign ap_y     = sat(XW'(ap_b) - XW'(ap_x));
    assign ap_half  = (XW'(ap_b) + XW'(1)) >>> 1;
    assign ap_wdata = sat(XW'(ap_x) + ap_half);

    scar_delay_ram #(
        .DEPTH (AMD),
        .WIDTH (SW)
    ) u_ap_ram (
        .clk   (clk),
        .we    (ap_cmp_en),
        .waddr (ap_waddr),
        .wdata (ap_wdata),
        .raddr (ap_raddr),
        .rdata (ap_rdata)
    );

    // shared multiplier operand select
    logic signed [SW-1:0] mul_a;
    logic [GW-1:0]        mul_g;

    always_comb
    begin
        mul_a = '0;
        mul_g = '0;
        if (comb_dat_en)
        begin
            mul_a = comb_y;
            mul_g = fb;
        end
        else if (run && st_reg == STW'(ST_DRY_L))
        begin
            mul_a = left_reg;
            mul_g = dry_c;
        end
        else if (run && st_reg == STW'(ST_DRY_R))
        begin
            mul_a = right_reg;
            mul_g = dry_c;
        end
        else if (run && st_reg == STW'(ST_WET_L))
        begin
            mul_a = rev_l_reg;
            mul_g = wet_c;
        end
        else if (run && st_reg == STW'(ST_WET_R))
        begin
            mul_a = rev_r_reg;
            mul_g = wet_c;
        end
    end

    logic signed [SW:0] lr_sum;
    assign lr_sum = (SW + 1)'(left_in) + (SW + 1)'(right_in);

    // datapath
    always_ff @(posedge clk)
    begin
        fb_prod_reg <= scar_pkg::FB_P_W'(fb_x) * scar_pkg::FB_P_W'(scar_pkg::FB_RECIP);
        prod_reg    <= PW'(mul_a) * PW'($signed({1'b0, mul_g}));
        comb_ok_reg <= comb_rd_en && (frames_reg >= FW'(comb_d));
        ap_ok_reg   <= ap_rd_en && (frames_reg >= FW'(ap_d));
        if (accept)
        begin
            left_reg  <= left_in;
            right_reg <= right_in;
            mono_reg  <= lr_sum[SW:1];
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        // comb outputs: even lines left, odd lines right
        if (comb_dat_en)
        begin
            if (comb_dat_idx[0])
            begin
                acc_r_reg <= acc_r_reg + ACW'(comb_y);
            end
            else
            begin
                acc_l_reg <= acc_l_reg + ACW'(comb_y);
            end
        end
        // all-pass chain, one stage per cycle
        if (ap_cmp_en)
        begin
            x_reg <= ap_y;
            if (ap_cmp_s == SIW'(A - 1))
            begin
                if (ap_cmp_ch)
                begin
                    rev_r_reg <= ap_y;
                end
                else
                begin
                    rev_l_reg <= ap_y;
                end
            end
        end
        // output mix
        if (run && st_reg == STW'(ST_DRY_L + 1))
        begin
            dry_l_reg <= rnd;
        end
        if (run && st_reg == STW'(ST_DRY_R + 1))
        begin
            dry_r_reg <= rnd;
        end
        if (run && st_reg == STW'(ST_SUM_L))
        begin
            sum_l_reg <= sat(XW'(dry_l_reg) + XW'(rnd));
        end
        if (run && st_reg == STW'(ST_SUM_R))
        begin
            sum_r_reg <= sat(XW'(dry_r_reg) + XW'(rnd));
        end
        if (out_load)
        begin
            out_left_reg  <= sum_l_reg;
            out_right_reg <= sum_r_reg;
        end
    end

    // sequencer, positions, fill count and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            st_reg        <= '0;
            out_valid_reg <= 1'b0;
            comb_pos_reg  <= '0;
            ap_pos_reg    <= '0;
            frames_reg    <= '0;
            room_reg      <= scar_pkg::RST_ROOM_SIZE;
            wet_reg       <= scar_pkg::RST_WET_GAIN;
            dry_reg       <= scar_pkg::RST_DRY_GAIN;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    scar_pkg::REG_ROOM_SIZE: room_reg <= cfg_data;
                    scar_pkg::REG_WET_GAIN:  wet_reg  <= cfg_data;
                    scar_pkg::REG_DRY_GAIN:  dry_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_RUN;
                        st_reg    <= '0;
                    end
                end
                S_RUN:
                begin
                    st_reg <= st_reg + STW'(1);
                    if (st_reg == STW'(ST_SUM_R))
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                        comb_pos_reg  <= (comb_pos_reg == CPW'(COMB_DEPTH - 1)) ? '0
                                         : comb_pos_reg + CPW'(1);
                        ap_pos_reg    <= (ap_pos_reg == APW'(ALLPASS_DEPTH - 1)) ? '0
                                         : ap_pos_reg + APW'(1);
                        if (frames_reg != FW'(COMB_DEPTH))
                        begin
                            frames_reg <= frames_reg + FW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `SCAR_ASSERT_NEXT(a_start, in_valid && in_ready, state_reg == S_RUN && st_reg == '0)
    `SCAR_ASSERT_IMPL(a_out_rise, $rose(out_valid_reg), $past(state_reg) == S_DONE)
    `SCAR_ASSERT_IMPL(a_fill, frames_reg < FW'(COMB_DEPTH), comb_pos_reg == CPW'(frames_reg))

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

// Reverb predictor and result checker
class reverb_scoreboard;
    localparam int NCOMB  = 8;
    localparam int NAP    = 4;
    localparam int CDEPTH = 2048;
    localparam int ADEPTH = 1024;
    localparam longint SMAX = 64'sd8388607;
    localparam longint SMIN = -64'sd8388608;

    int comb_tune [NCOMB] = '{1557, 1617, 1491, 1422, 1277, 1356, 1188, 1116};
    int ap_tune [NAP]     = '{556, 441, 341, 225};

    logic [15:0] room_size;
    logic [15:0] wet_gain;
    logic [15:0] dry_gain;
    longint comb_line [NCOMB][CDEPTH];
    longint ap_line [2][NAP][ADEPTH];
    int comb_pos [NCOMB];
    int ap_pos [NAP];

    logic signed [23:0] exp_left [$];
    logic signed [23:0] exp_right [$];
    int errors;

    function new();
        room_size = scar_pkg::RST_ROOM_SIZE;
        wet_gain  = scar_pkg::RST_WET_GAIN;
        dry_gain  = scar_pkg::RST_DRY_GAIN;
        foreach (comb_line[i, j]) comb_line[i][j] = 0;
        foreach (ap_line[c, s, j]) ap_line[c][s][j] = 0;
        foreach (comb_pos[i]) comb_pos[i] = 0;
        foreach (ap_pos[i]) ap_pos[i] = 0;
        errors = 0;
    endfunction

    function longint sat(longint v);
        if (v > SMAX) return SMAX;
        if (v < SMIN) return SMIN;
        return v;
    endfunction

    // rounds half up: floor((a*g + half) / one)
    function longint q15_mul(longint a, longint g);
        return (a * g + scar_pkg::Q15_HALF) >>> scar_pkg::Q15_SHIFT;
    endfunction

    function longint clamp_gain(logic [15:0] g);
        return (g > scar_pkg::Q15_ONE) ? scar_pkg::Q15_ONE : longint'(g);
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            scar_pkg::REG_ROOM_SIZE: room_size = val;
            scar_pkg::REG_WET_GAIN:  wet_gain  = val;
            scar_pkg::REG_DRY_GAIN:  dry_gain  = val;
            default: ;
        endcase
    endfunction

    // note an accepted request, predict its frame
    function void note_request(logic signed [23:0] l, logic signed [23:0] r);
        longint left, right, mono, fb, y, b, x, ol, orr;
        longint acc [2];
        longint rev [2];
        int rd;
        left  = l;
        right = r;
        mono  = (left + right) >>> 1;
        fb    = (clamp_gain(room_size) * 9 + 5) / 10 + scar_pkg::FB_OFFSET;
        acc[0] = 0;
        acc[1] = 0;
        for (int i = 0; i < NCOMB; i++)
        begin
            rd = (comb_pos[i] + CDEPTH - comb_tune[i]) % CDEPTH;
            y = comb_line[i][rd];
            comb_line[i][comb_pos[i]] = sat(mono + q15_mul(y, fb));
            comb_pos[i] = (comb_pos[i] + 1) % CDEPTH;
            acc[i % 2] += y;
        end
        for (int c = 0; c < 2; c++)
        begin
            rev[c] = sat(acc[c]);
            for (int s = 0; s < NAP; s++)
            begin
                x = rev[c];
                rd = (ap_pos[s] + ADEPTH - ap_tune[s]) % ADEPTH;
                b = ap_line[c][s][rd];
                ap_line[c][s][ap_pos[s]] = sat(x + q15_mul(b, scar_pkg::Q15_HALF));
                rev[c] = sat(b - x);
            end
        end
        for (int s = 0; s < NAP; s++) ap_pos[s] = (ap_pos[s] + 1) % ADEPTH;
        ol  = sat(q15_mul(left, clamp_gain(dry_gain)) + q15_mul(rev[0], clamp_gain(wet_gain)));
        orr = sat(q15_mul(right, clamp_gain(dry_gain)) + q15_mul(rev[1], clamp_gain(wet_gain)));
        exp_left.insert(exp_left.size(), ol[23:0]);
        exp_right.insert(exp_right.size(), orr[23:0]);
    endfunction

    function void check_frame(logic signed [23:0] l, logic signed [23:0] r);
        logic signed [23:0] el, er;
        if (exp_left.size() == 0)
        begin
            $error("unexpected output frame left_out=%0d right_out=%0d", l, r);
            errors++;
            return;
        end
        el = exp_left.pop_front();
        er = exp_right.pop_front();
        if (l !== el)
        begin
            $error("left_out expected %0d actual %0d", el, l);
            errors++;
        end
        if (r !== er)
        begin
            $error("right_out expected %0d actual %0d", er, r);
            errors++;
        end
    endfunction

    function int pending();
        return exp_left.size();
    endfunction
endclass

module tb_top;
    localparam int RANDOM_FRAMES = 1950;
    localparam int STALL_LIMIT   = 20000;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [scar_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [scar_pkg::GAIN_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
    logic out_valid;
    logic out_ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;

    reverb_scoreboard frames = new();
    int idle_cycles;

    stereo_comb_allpass_reverb_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // scoring at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            frames.note_request(left_in, right_in);
        if (rst_n && out_valid && out_ready)
            frames.check_frame(left_out, right_out);
    end

    // watchdog: cycles with no request or result moved
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls before each frame
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5));
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // valid stays high into the next request when there is no gap
    task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, bit nogap = 0);
        int gap;
        gap = nogap ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // settle fully before register writes
    task automatic drain();
        in_valid <= 1'b0;
        while (frames.pending() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        frames.write_reg(idx, val);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return $signed(24'($urandom_range(0, 255)) - 24'd128);
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        int burst;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        left_in   = '0;
        right_in  = '0;
        idle_cycles = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: extremes, impulse, mixed signs under reset gains
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(24'sh800000, 24'sh800000);
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(-24'sd1, 24'sd0);
        send_frame(24'sd1, -24'sd2);
        send_frame(-24'sd1, -24'sd1);
        for (int i = 0; i < 6; i++) send_frame(24'sd0, 24'sd0, 1);

        // gains above one clamp, unknown index ignored
        write_reg(scar_pkg::REG_ROOM_SIZE, 16'hFFFF);
        write_reg(scar_pkg::REG_WET_GAIN, 16'hFFFF);
        write_reg(scar_pkg::REG_DRY_GAIN, 16'd40000);
        write_reg(2'd3, 16'h1234);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF);
        send_frame(24'sh800000, 24'sh7FFFFF);
        write_reg(scar_pkg::REG_ROOM_SIZE, 16'd0);
        write_reg(scar_pkg::REG_WET_GAIN, 16'd0);
        write_reg(scar_pkg::REG_DRY_GAIN, 16'd0);
        send_frame(24'sh7FFFFF, 24'sh800000);
        send_frame(24'sd12345, -24'sd777);
        write_reg(scar_pkg::REG_ROOM_SIZE, 16'd32768);
        write_reg(scar_pkg::REG_WET_GAIN, 16'd32768);
        write_reg(scar_pkg::REG_DRY_GAIN, 16'd32768);
        send_frame(24'sh400000, -24'sh400000);

        // random phases, each with fresh settings
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(scar_pkg::REG_ROOM_SIZE, (ph == 5) ? 16'd32768 : 16'($urandom_range(0, 36000)));
            write_reg(scar_pkg::REG_WET_GAIN, 16'($urandom));
            write_reg(scar_pkg::REG_DRY_GAIN, 16'($urandom_range(0, 32768)));
            burst = 0;
            for (int i = 0; i < RANDOM_FRAMES / 6; i++)
            begin
                // some back-to-back stretches
                if (burst > 0)
                begin
                    send_frame(rand_sample(), rand_sample(), 1);
                    burst--;
                end
                else
                begin
                    send_frame(rand_sample(), rand_sample());
                    if ($urandom_range(0, 40) == 0) burst = $urandom_range(5, 30);
                end
            end
            // pause until all results return
            in_valid <= 1'b0;
            while (frames.pending() != 0) @(negedge clk);
        end

        drain();
        if (frames.errors == 0 && frames.pending() == 0)
            $display("No mismatches found");
        else
        begin
            if (frames.pending() != 0)
                $error("%0d expected frames never arrived", frames.pending());
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
